### rtl/bxd2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxd2_pkg
// Shared types and constants of the 2x2 box-filter downscaler.
// ----------------------------------------------------------------------------
package bxd2_pkg;

    // Default size limits (top-level parameter defaults)
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Register field widths and reset values
    localparam int FRAME_WIDTH_W   = 11;
    localparam int FRAME_HEIGHT_W  = 13;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_INDEX_W     = 1;
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Smallest usable frame dimension
    localparam int MIN_SIZE = 2;

    // Pixel and sum widths
    localparam int PIX_W   = 8;
    localparam int PAIR_W  = 9;
    localparam int TOTAL_W = 10;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Operation handed from front to back (line-store slot travels beside it)
    typedef struct packed {
        logic              emit;   // 1: odd row, add to stored sum and emit
        logic              last;   // final block of the frame
        logic [PAIR_W-1:0] sum;    // horizontal pair sum
    } bxd2_op_t;

endpackage

### rtl/box_downscale_2x2_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downscale_2x2_core
// 2x2 box-filter downscaler for 8-bit grey frames in raster order.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock and emits one pixel per 2x2 source block,
// the truncated mean of its four pixels, with tlast on the final block of the
// frame. Throughput is one pixel per clock: the front takes a pixel at every
// edge while the four-entry queue has room, and the back end, whose
// single-port line store takes one write or one read per cycle, sees at most
// one operation per two pixels. The operation of a completed block passes
// through the queue, the stage-1 registers and the output register before
// its word is presented. Even rows only fill the line store (MAX_WIDTH/2
// entries of 9-bit pair sums); odd rows produce output. With an odd width
// the last column is dropped, with an odd height the last row. frame_width
// and frame_height are saturated to [2, MAX_WIDTH] and [2, MAX_HEIGHT];
// write them only while the block is idle. The line store has no reset
// pass, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module box_downscale_2x2_core
    import bxd2_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // source pixels
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] pixel_value
    // averaged pixels
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] averaged_pixel
    output logic                   m_tlast    // frame_last
);

    localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int OP_W       = $bits(bxd2_op_t);
    localparam int Q_W        = SLOT_W + OP_W;

    logic              q_full, q_empty, op_push, q_pop;
    bxd2_op_t          op_data, head_op;
    logic [SLOT_W-1:0] op_slot, head_slot;
    logic [Q_W-1:0]    push_word, head_word;

    bxd2_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SLOT_W     (SLOT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pixel   (s_tdata[PIX_W-1:0]),
        .q_full    (q_full),
        .op_push   (op_push),
        .op_data   (op_data),
        .op_slot   (op_slot)
    );

    // Pack operation and slot into one queue word
    assign push_word = {op_slot, op_data};
    assign head_slot = head_word[Q_W-1:OP_W];
    assign head_op   = head_word[OP_W-1:0];

    bxd2_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (op_push),
        .push_data (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_data (head_word)
    );

    bxd2_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .SLOT_W     (SLOT_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_op     (head_op),
        .q_slot   (head_slot),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_pixel  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/bxd2_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxd2_front
// Accepts source pixels, tracks the raster position, forms horizontal pair
// sums and classifies each pair as a line-store write or a block output.
// ----------------------------------------------------------------------------
module bxd2_front
    import bxd2_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int SLOT_W     = 9
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // pixel input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIX_W-1:0]       s_pixel,
    // operation output to queue
    input  logic                   q_full,
    output logic                   op_push,
    output bxd2_op_t               op_data,
    output logic [SLOT_W-1:0]      op_slot
);

    localparam int CW     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCW_A  = $clog2(MAX_WIDTH + 1);
    localparam int HCW_A  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW    = (WCW_A > FRAME_WIDTH_W) ? WCW_A : FRAME_WIDTH_W;
    localparam int HCW    = (HCW_A > FRAME_HEIGHT_W) ? HCW_A : FRAME_HEIGHT_W;

    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [CW-1:0]             col_reg, col_next;
    logic [RW-1:0]             row_reg, row_next;
    logic [PIX_W-1:0]          pair_reg;

    logic [WCW-1:0] fw, w_eff, w_even, col_x, col_inc;
    logic [HCW-1:0] fh, h_eff, h_even, row_x, row_inc;
    logic           accept, in_frame;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate frame size to the supported range
    always_comb begin
        fw = WCW'(frame_width_reg);
        fh = HCW'(frame_height_reg);
        if (fw < WCW'(MIN_SIZE))       w_eff = WCW'(MIN_SIZE);
        else if (fw > WCW'(MAX_WIDTH)) w_eff = WCW'(MAX_WIDTH);
        else                           w_eff = fw;
        if (fh < HCW'(MIN_SIZE))        h_eff = HCW'(MIN_SIZE);
        else if (fh > HCW'(MAX_HEIGHT)) h_eff = HCW'(MAX_HEIGHT);
        else                            h_eff = fh;
        w_even = {w_eff[WCW-1:1], 1'b0};
        h_even = {h_eff[HCW-1:1], 1'b0};
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Classify the current pixel
    always_comb begin
        col_x    = WCW'(col_reg);
        row_x    = HCW'(row_reg);
        in_frame = (col_x < w_even) && (row_x < h_even);
        op_push      = accept && in_frame && col_reg[0];
        op_data.emit = row_reg[0];
        op_data.sum  = PAIR_W'(pair_reg) + PAIR_W'(s_pixel);
        op_data.last = (row_x == h_even - HCW'(1)) && (col_x == w_even - WCW'(1));
        op_slot      = SLOT_W'(col_reg >> 1);
    end

    // Advance the raster position, wrap at the frame bounds
    always_comb begin
        col_inc = col_x + WCW'(1);
        row_inc = row_x;
        if (col_inc >= w_eff) begin
            col_inc = '0;
            row_inc = row_x + HCW'(1);
        end
        if (row_inc >= h_eff) row_inc = '0;
        col_next = CW'(col_inc);
        row_next = RW'(row_inc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pair_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_frame && !col_reg[0]) pair_reg <= s_pixel;
        end
    end

endmodule

### rtl/bxd2_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxd2_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module bxd2_queue
    import bxd2_pkg::*;
#(
    parameter int DATA_W = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output logic [DATA_W-1:0] head_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]     count_reg, count_next;

    assign full      = (count_reg == NW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = entry_reg[rd_ptr_reg];

    // Track fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + NW'(1);
        else if (pop && !push) count_next = count_reg - NW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PW'(1);
        end
    end

    // Store pushed words
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/bxd2_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bxd2_back
// Executes queued operations against the line store and produces the
// averaged output pixels through a registered output stage.
// ----------------------------------------------------------------------------
module bxd2_back
    import bxd2_pkg::*;
#(
    parameter int LINE_DEPTH = 512,
    parameter int SLOT_W     = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    // queue head
    input  logic              q_empty,
    input  bxd2_op_t          q_op,
    input  logic [SLOT_W-1:0] q_slot,
    output logic              q_pop,
    // result output
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [PIX_W-1:0]  m_pixel,
    output logic              m_tlast
);

    logic [PAIR_W-1:0] line_mem [LINE_DEPTH];

    logic              s1_valid_reg;
    logic [PAIR_W-1:0] s1_above_reg;
    logic [PAIR_W-1:0] s1_sum_reg;
    logic              s1_last_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              out_last_reg;

    logic              s2_adv, s1_adv;
    logic [TOTAL_W-1:0] total;

    assign s2_adv = !out_valid_reg || m_tready;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign q_pop  = !q_empty && s1_adv;

    // Line store: write even-row pair sums, read the sum above on odd rows
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (q_op.emit) s1_above_reg <= line_mem[q_slot];
            else           line_mem[q_slot] <= q_op.sum;
        end
    end

    // Stage 1: hold the read-side operation beside the memory data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= q_pop && q_op.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_op.emit) begin
            s1_sum_reg  <= q_op.sum;
            s1_last_reg <= q_op.last;
        end
    end

    // Stage 2: add the two pair sums, divide by four
    assign total = TOTAL_W'(s1_above_reg) + TOTAL_W'(s1_sum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv && s1_valid_reg) begin
            out_pixel_reg <= total[TOTAL_W-1:2];
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_pixel  = out_pixel_reg;
    assign m_tlast  = out_last_reg;

endmodule
